// ===== design/spbs_pkg.sv =====
// Shared types and constants of the sparse page bitmap set unit.
// Used by spbs_cfg and sparse_page_bitmap_set_unit; depends on nothing.
`default_nettype none
package spbs_pkg;

  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned OFF_W      = 8;
  localparam int unsigned WSEL_W     = 2;
  localparam int unsigned PHYS_W     = 8;
  localparam int unsigned LBLK_W     = PAGE_W - OFF_W;
  localparam int unsigned STORE_AW   = PHYS_W + WSEL_W;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned ANCHOR_W   = PHYS_W + 1;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [STORE_AW-1:0] CLEAR_LAST  = '1;
  localparam logic [PAGE_W-1:0]   MAX_PAGE_RST    = 16'hFFFF;
  localparam logic [LIMIT_W-1:0]  BLOCK_LIMIT_RST = 9'd256;

  localparam logic REG_MAX_PAGE    = 1'b0;
  localparam logic REG_BLOCK_LIMIT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  localparam logic CMD_INSERT = 1'b0;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ANCH,
    S_BITS
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0]  max_page;
    logic [LIMIT_W-1:0] block_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/spbs_cfg.sv =====
// APB configuration registers: maximum page number and block limit.
// Depends on spbs_pkg.
`default_nettype none
module spbs_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spbs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [spbs_pkg::PDATA_W-1:0] pwdata,
  output logic      [spbs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output spbs_pkg::cfg_t                   cfg_o
);
  import spbs_pkg::*;

  logic [PAGE_W-1:0]  max_page_q, max_page_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    max_page_d = max_page_q;
    limit_d    = limit_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_PAGE:    max_page_d = pwdata[PAGE_W-1:0];
        REG_BLOCK_LIMIT: limit_d    = pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_PAGE:    prdata = {{(PDATA_W-PAGE_W){1'b0}}, max_page_q};
      REG_BLOCK_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_page_q <= MAX_PAGE_RST;
      limit_q    <= BLOCK_LIMIT_RST;
    end else begin
      max_page_q <= max_page_d;
      limit_q    <= limit_d;
    end
  end

  assign cfg_o.max_page    = max_page_q;
  assign cfg_o.block_limit = limit_q;

endmodule
`default_nettype wire

// ===== design/sparse_page_bitmap_set_unit.sv =====
// Sparse page bitmap set: anchor memory, bit-word memory and command sequencer.
// Depends on spbs_pkg and spbs_cfg.
//
// After reset the unit sweeps both memories to zero and takes no word until
// done. Each command then has an anchor stage (anchor memory read, allocating
// a physical block on the first insert into a logical block) and a bit word
// stage for the read-modify-write of the 64-bit bit word, skipped when the
// command needs no bit word. A new word is taken in the bit word stage of the
// previous one; a stalled result output holds the next command in its anchor
// stage. Results come out one register stage after the last stage of a command.
`default_nettype none
module sparse_page_bitmap_set_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [spbs_pkg::PAGE_W-1:0]  s_axis_tdata,   // [15:0] page_number
  input  wire logic                         s_axis_tuser,   // [0] command
  // result
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [23:0]                  m_axis_tdata,   // [16:0] page_count, zero pad
  output logic      [spbs_pkg::STATUS_W-1:0] m_axis_tuser,  // [2:0] status
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spbs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [spbs_pkg::PDATA_W-1:0] pwdata,
  output logic      [spbs_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import spbs_pkg::*;

  cfg_t cfg;

  spbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // memories
  logic [ANCHOR_W-1:0] anc_mem [2**LBLK_W];
  logic [WORD_W-1:0]   bit_mem [2**STORE_AW];

  logic [ANCHOR_W-1:0] anc_rdata_q;
  logic [WORD_W-1:0]   bit_rdata_q;

  state_e state_q, state_d;

  logic [STORE_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic                cmd_q;
  logic [PAGE_W-1:0]   page_q;
  logic [STORE_AW-1:0] bit_addr_q;
  logic [LIMIT_W-1:0]  used_q, used_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                m_valid_q, m_valid_d;
  logic [STATUS_W-1:0] m_status_q;
  logic [COUNT_W-1:0]  m_count_q;

  logic                accept;
  logic                out_free;
  logic                in_range;
  logic                anc_hit;
  logic                limit_hit;
  logic                alloc;
  logic                go_bits;
  logic [PHYS_W-1:0]   phys;
  logic [STATUS_W-1:0] early_status;
  logic                bit_set;
  logic [WORD_W-1:0]   bit_mask;

  logic                anc_re, anc_we;
  logic [LBLK_W-1:0]   anc_waddr;
  logic [ANCHOR_W-1:0] anc_wdata;
  logic                bit_re, bit_we;
  logic [STORE_AW-1:0] bit_raddr, bit_waddr;
  logic [WORD_W-1:0]   bit_wdata;
  logic                out_we;
  logic [STATUS_W-1:0] out_status;
  logic                count_up, count_dn;

  assign s_axis_tready = (state_q == S_IDLE) || (state_q == S_BITS);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // anchor stage decode
  assign in_range  = page_q <= cfg.max_page;
  assign anc_hit   = anc_rdata_q[ANCHOR_W-1];
  assign limit_hit = used_q[LIMIT_W-1] || (used_q >= cfg.block_limit);
  assign alloc     = in_range && (cmd_q == CMD_INSERT) && !anc_hit && !limit_hit;
  assign go_bits   = in_range && (anc_hit || alloc);
  assign phys      = anc_hit ? anc_rdata_q[PHYS_W-1:0] : used_q[PHYS_W-1:0];
  assign bit_raddr = {phys, page_q[OFF_W-1:BIT_W]};

  always_comb begin
    if (!in_range) begin
      early_status = ST_RANGE;
    end else if (cmd_q != CMD_INSERT) begin
      early_status = ST_ABSENT;
    end else begin
      early_status = ST_FULL;
    end
  end

  // bit word stage
  assign bit_set  = bit_rdata_q[page_q[BIT_W-1:0]];
  assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << page_q[BIT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == CLEAR_LAST) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_ANCH;
      S_ANCH: begin
        if (out_free) state_d = go_bits ? S_BITS : S_IDLE;
      end
      S_BITS:  state_d = accept ? S_ANCH : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    anc_re     = accept;
    anc_we     = 1'b0;
    anc_waddr  = page_q[PAGE_W-1:OFF_W];
    anc_wdata  = {1'b1, used_q[PHYS_W-1:0]};
    bit_re     = 1'b0;
    bit_we     = 1'b0;
    bit_waddr  = bit_addr_q;
    bit_wdata  = bit_rdata_q;
    out_we     = 1'b0;
    out_status = early_status;
    count_up   = 1'b0;
    count_dn   = 1'b0;
    clr_cnt_d  = clr_cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        anc_we    = 1'b1;
        anc_waddr = clr_cnt_q[LBLK_W-1:0];
        anc_wdata = '0;
        bit_we    = 1'b1;
        bit_waddr = clr_cnt_q;
        bit_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      S_IDLE: ;
      S_ANCH: begin
        if (out_free) begin
          anc_we = alloc;
          bit_re = go_bits;
          out_we = !go_bits;
        end
      end
      S_BITS: begin
        out_we = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          bit_we     = !bit_set;
          bit_wdata  = bit_rdata_q | bit_mask;
          out_status = bit_set ? ST_DUP : ST_OK;
          count_up   = !bit_set;
        end else begin
          bit_we     = bit_set;
          bit_wdata  = bit_rdata_q & ~bit_mask;
          out_status = bit_set ? ST_OK : ST_ABSENT;
          count_dn   = bit_set;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (state_q == S_ANCH && out_free && alloc) used_d = used_q + 1'b1;
  end

  always_comb begin
    count_d = count_q;
    if (count_up && count_q != COUNT_MAX) begin
      count_d = count_q + 1'b1;
    end else if (count_dn && count_q != '0) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_we) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    if (anc_re) anc_rdata_q <= anc_mem[s_axis_tdata[PAGE_W-1:OFF_W]];
  end

  always_ff @(posedge clk_i) begin
    if (bit_we) bit_mem[bit_waddr] <= bit_wdata;
    if (bit_re) bit_rdata_q <= bit_mem[bit_raddr];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      used_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      used_q    <= used_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser;
      page_q <= s_axis_tdata;
    end
    if (bit_re) bit_addr_q <= bit_raddr;
    if (out_we) begin
      m_status_q <= out_status;
      m_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(24-COUNT_W){1'b0}}, m_count_q};

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for sparse_page_bitmap_set_unit: drives insert/remove words and
// checks status and page count against a behavioral copy of the page set.
// Depends on spbs_pkg and the unit's RTL.
module tb;
  import spbs_pkg::*;

  localparam logic CMD_REMOVE = ~CMD_INSERT;
  localparam int   QUIET_LIMIT = 5000;
  localparam int   PRINT_CAP = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } page_result_t;

  class page_set_scoreboard;
    logic [PAGE_W-1:0]  max_page = MAX_PAGE_RST;
    logic [LIMIT_W-1:0] block_limit = BLOCK_LIMIT_RST;
    bit                 block_mapped [256];
    bit [PHYS_W-1:0]    block_phys [256];
    bit [255:0]         page_bits [256];
    int unsigned        blocks_used;
    logic [COUNT_W-1:0] pages_held = '0;
    page_result_t       expected_q [$];
    int                 errors;
    int                 n_checked;
    int                 status_seen [5];

    function void set_register(logic idx, logic [PDATA_W-1:0] value);
      if (idx == REG_MAX_PAGE) max_page = value[PAGE_W-1:0];
      else block_limit = value[LIMIT_W-1:0];
    endfunction

    function void note_command(logic cmd, logic [PAGE_W-1:0] page);
      logic [LBLK_W-1:0]   lblk;
      logic [OFF_W-1:0]    off;
      int unsigned         usable;
      logic [STATUS_W-1:0] st;
      page_result_t        res;
      lblk = page[PAGE_W-1:OFF_W];
      off = page[OFF_W-1:0];
      usable = (block_limit > 256) ? 256 : block_limit;
      st = ST_OK;
      if (page > max_page) begin
        st = ST_RANGE;
      end else if (cmd == CMD_INSERT) begin
        if (!block_mapped[lblk] && blocks_used >= usable) begin
          st = ST_FULL;
        end else begin
          if (!block_mapped[lblk]) begin
            block_mapped[lblk] = 1'b1;
            block_phys[lblk] = blocks_used[PHYS_W-1:0];
            blocks_used++;
          end
          if (page_bits[block_phys[lblk]][off]) begin
            st = ST_DUP;
          end else begin
            page_bits[block_phys[lblk]][off] = 1'b1;
            if (pages_held != COUNT_MAX) pages_held++;
          end
        end
      end else begin
        if (!block_mapped[lblk] || !page_bits[block_phys[lblk]][off]) begin
          st = ST_ABSENT;
        end else begin
          page_bits[block_phys[lblk]][off] = 1'b0;
          if (pages_held != 0) pages_held--;
        end
      end
      res.status = st;
      res.count = pages_held;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
      page_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d count=%0d", st, cnt));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.status <= ST_FULL) status_seen[want.status]++;
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (cnt !== want.count)
        report_mismatch($sformatf("page_count %0d, want %0d", cnt, want.count));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PAGE_W-1:0]   s_axis_tdata = '0;   // [15:0] page_number
  logic                s_axis_tuser = 1'b0; // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [16:0] page_count, zero pad
  logic [STATUS_W-1:0] m_axis_tuser;        // [2:0] status
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  page_set_scoreboard sb;
  int snd_idle_pct;
  int rcv_idle_pct;
  int rcv_hold;
  int quiet_cycles;
  int n_sent;

  sparse_page_bitmap_set_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[COUNT_W-1:0]);
    if (rcv_hold > 0) begin
      m_axis_tready <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task feed(logic cmd, logic [PAGE_W-1:0] page);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= page;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, page);
    n_sent++;
  endtask

  task settle(int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task write_regs(logic [PAGE_W-1:0] max_page, logic [LIMIT_W-1:0] limit);
    logic [PDATA_W-1:0] value;
    for (int r = 0; r < 2; r++) begin
      value = (r == 0) ? PDATA_W'(max_page) : PDATA_W'(limit);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {(r == 0) ? REG_MAX_PAGE : REG_BLOCK_LIMIT, 2'b00};
      pwdata <= value;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      sb.set_register((r == 0) ? REG_MAX_PAGE : REG_BLOCK_LIMIT, value);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task run_random(int ph, int items);
    logic [LBLK_W-1:0] hot [4];
    logic [PAGE_W-1:0] page;
    logic              cmd;
    logic [OFF_W-1:0]  off;
    foreach (hot[k]) hot[k] = LBLK_W'($urandom_range(0, 255));
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 75) begin
        off = ($urandom_range(3) == 0) ? OFF_W'($urandom_range(255))
                                       : OFF_W'($urandom_range(40));
        page = {hot[$urandom_range(3)], off};
      end else begin
        page = PAGE_W'($urandom_range(0, 16'hFFFF));
      end
      cmd = ($urandom_range(99) < 45) ? CMD_REMOVE : CMD_INSERT;
      if (ph == 4 && i == 30) rcv_hold = 300;
      if (ph == 5 && i == 150) settle(0);
      feed(cmd, page);
    end
  endtask

  initial begin
    int n_directed;
    sb = new;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: reset registers
    feed(CMD_INSERT, 16'h0000);
    feed(CMD_INSERT, 16'h0000);
    feed(CMD_INSERT, 16'hFFFF);
    feed(CMD_REMOVE, 16'h0000);
    feed(CMD_REMOVE, 16'h0000);
    feed(CMD_REMOVE, 16'h1234);
    feed(CMD_INSERT, 16'h5555);
    feed(CMD_INSERT, 16'hAAAA);
    feed(CMD_INSERT, 16'h00FF);
    feed(CMD_INSERT, 16'h003F);
    feed(CMD_INSERT, 16'h0040);
    settle(4);
    // lower max below held page, lower limit below blocks in use
    write_regs(16'h7FFF, 9'd2);
    feed(CMD_INSERT, 16'h8000);
    feed(CMD_REMOVE, 16'hFFFF);
    feed(CMD_INSERT, 16'h0100);
    feed(CMD_INSERT, 16'h0001);
    feed(CMD_REMOVE, 16'h5555);
    settle(4);
    write_regs(16'hFFFF, 9'd0);
    feed(CMD_INSERT, 16'h2222);
    feed(CMD_INSERT, 16'hAAAB);
    settle(4);
    write_regs(16'h0000, 9'h1FF);
    feed(CMD_INSERT, 16'h0000);
    feed(CMD_INSERT, 16'h0001);
    feed(CMD_REMOVE, 16'h0001);
    n_directed = n_sent;

    for (int ph = 0; ph < 6; ph++) begin
      settle(4);
      write_regs((ph % 2 == 0) ? 16'hFFFF : PAGE_W'($urandom_range(16'h2000, 16'hFFFE)),
                 (ph == 1) ? 9'd1 : LIMIT_W'($urandom_range(1, 511)));
      snd_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 86 : 0;
      rcv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 6 : 0;
      run_random(ph, 250);
    end

    settle(20);
    $display("Sent %0d commands (%0d directed), checked %0d results, %0d mismatches",
             n_sent, n_directed, sb.n_checked, sb.errors);
    $display("Status mix ok/dup/absent/range/full: %0d/%0d/%0d/%0d/%0d, blocks used %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4], sb.blocks_used);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/spbs_pkg.sv
design/spbs_cfg.sv
design/sparse_page_bitmap_set_unit.sv
tb/tb.sv
